// ===== sv/edf_fixed_priority_job_select_macros.svh =====
// Assertion helpers used by the job select module.
`ifndef EDF_FIXED_PRIORITY_JOB_SELECT_MACROS_SVH
`define EDF_FIXED_PRIORITY_JOB_SELECT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EFPJS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define EFPJS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/efpjs_pkg.sv =====
`default_nettype none

package efpjs_pkg;

  localparam int unsigned PROC_W   = 3;
  localparam int unsigned TIME_W   = 31;
  localparam int unsigned PRIO_W   = 16;
  localparam int unsigned DL_W     = 32;
  localparam int unsigned TASK_W   = 8;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned PREC_W   = 8;
  localparam int unsigned INDEX_W  = 8;

  localparam int unsigned IN_DATA_W  = 152;
  localparam int unsigned OUT_DATA_W = 40;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_JOB  = 1'b1
  } kind_e;

  // Packed with processor_id in the lowest bits.
  typedef struct packed {
    logic [PREC_W-1:0]       precedence_id;
    logic [PERIOD_W-1:0]     period_id;
    logic [TASK_W-1:0]       task_id;
    logic signed [DL_W-1:0]  deadline;
    logic [PRIO_W-1:0]       priority_req;
    logic [TIME_W-1:0]       release_time;
    logic [TIME_W-1:0]       timestamp;
    logic [PROC_W-1:0]       processor_id;
  } req_t;

  // Packed with picked_index in the lowest bits.
  typedef struct packed {
    logic [PREC_W-1:0]   picked_precedence;
    logic [PERIOD_W-1:0] picked_period;
    logic [TASK_W-1:0]   picked_task;
    logic [INDEX_W-1:0]  picked_index;
  } result_t;

  typedef struct packed {
    logic [PRIO_W-1:0]      prio;
    logic signed [DL_W-1:0] deadline;
    logic [TASK_W-1:0]      task_id;
  } key_t;

  typedef struct packed {
    logic              eligible;
    logic              have_best;
    logic              same_proc;
    logic [TIME_W-1:0] mine;
    logic [TIME_W-1:0] theirs;
  } rank_ctl_t;

endpackage

`default_nettype wire

// ===== sv/efpjs_rank.sv =====
`default_nettype none

module efpjs_rank (
  input  efpjs_pkg::rank_ctl_t ctl_i,
  input  efpjs_pkg::key_t      chal_i,
  input  efpjs_pkg::key_t      best_i,
  output logic                 take_o
);

  logic chal_first;

  // Same processor: priority, then deadline (signed), then task id.
  always_comb begin
    if (chal_i.prio != best_i.prio) begin
      chal_first = chal_i.prio < best_i.prio;
    end else if (chal_i.deadline != best_i.deadline) begin
      chal_first = $signed(chal_i.deadline) < $signed(best_i.deadline);
    end else begin
      chal_first = chal_i.task_id < best_i.task_id;
    end
  end

  always_comb begin
    if (!ctl_i.eligible) begin
      take_o = 1'b0;
    end else if (!ctl_i.have_best) begin
      take_o = 1'b1;
    end else begin
      take_o = (ctl_i.mine < ctl_i.theirs) || (ctl_i.same_proc && chal_first);
    end
  end

endmodule

`default_nettype wire

// ===== sv/edf_fixed_priority_job_select.sv =====
// Picks the next job to dispatch from a streamed candidate list. A request with
// tuser=0 loads one processor's current time; a request with tuser=1 is a
// candidate, eligible when its release time is at most its processor's time.
// The candidate marked by tlast closes the list and produces one result
// (tuser=1 when a job was found, else all-zero data) and starts a new list.
// One request is taken every clock cycle unless a held result stalls the input;
// a closing request passes through the input register, where the processor time
// lookup and the ranking compare run, and then into the result register. Only a
// held result stalls the input side, and only for a list-closing request.
`default_nettype none
`include "edf_fixed_priority_job_select_macros.svh"

module edf_fixed_priority_job_select #(
  parameter int unsigned NUM_PROCESSORS = 8
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // processor_id, timestamp, release_time, priority_req, deadline, task_id,
  // period_id, precedence_id, zero fill
  input  wire logic [efpjs_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // kind
  input  wire logic                                 s_axis_tuser,
  input  wire logic                                 s_axis_tlast,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // picked_index, picked_task, picked_period, picked_precedence
  output logic [efpjs_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
  // found
  output logic                                      m_axis_tuser
);

  localparam int unsigned TIME_W  = efpjs_pkg::TIME_W;
  localparam int unsigned PROC_W  = efpjs_pkg::PROC_W;
  localparam int unsigned INDEX_W = efpjs_pkg::INDEX_W;

  // Input register
  logic             s1_valid_q;
  efpjs_pkg::req_t  s1_req_q;
  efpjs_pkg::kind_e s1_kind_q;
  logic             s1_last_q;

  // Processor times and current pick
  logic [TIME_W-1:0]  proc_times_q [NUM_PROCESSORS];
  logic               have_best_q;
  logic [INDEX_W-1:0] seen_q;
  logic [PROC_W-1:0]  best_proc_q;
  efpjs_pkg::key_t    best_key_q;
  efpjs_pkg::result_t best_res_q;

  // Result register
  logic               m_valid_q;
  logic               m_found_q;
  efpjs_pkg::result_t m_data_q;

  logic                 mine_ok;
  logic [TIME_W-1:0]    mine;
  logic [TIME_W-1:0]    theirs;
  logic                 take;
  logic                 emit_req;
  logic                 commit;
  logic                 found_n;
  efpjs_pkg::result_t   chal_res;
  efpjs_pkg::result_t   sel_res;
  efpjs_pkg::key_t      chal_key;
  efpjs_pkg::rank_ctl_t rank_ctl;

  assign emit_req      = (s1_kind_q == efpjs_pkg::KIND_JOB) && s1_last_q;
  assign commit        = s1_valid_q && (!emit_req || !m_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || commit;

  always_comb begin
    mine_ok = 1'b0;
    mine    = '0;
    theirs  = '0;
    for (int p = 0; p < int'(NUM_PROCESSORS); p++) begin
      if (int'(s1_req_q.processor_id) == p) begin
        mine_ok = 1'b1;
        mine    = proc_times_q[p];
      end
      if (int'(best_proc_q) == p) begin
        theirs = proc_times_q[p];
      end
    end
  end

  assign chal_key.prio     = s1_req_q.priority_req;
  assign chal_key.deadline = s1_req_q.deadline;
  assign chal_key.task_id  = s1_req_q.task_id;

  assign rank_ctl.eligible  = (s1_kind_q == efpjs_pkg::KIND_JOB) && mine_ok &&
                              (s1_req_q.release_time <= mine);
  assign rank_ctl.have_best = have_best_q;
  assign rank_ctl.same_proc = s1_req_q.processor_id == best_proc_q;
  assign rank_ctl.mine      = mine;
  assign rank_ctl.theirs    = theirs;

  efpjs_rank u_rank (
    .ctl_i  (rank_ctl),
    .chal_i (chal_key),
    .best_i (best_key_q),
    .take_o (take)
  );

  assign chal_res.picked_index      = seen_q;
  assign chal_res.picked_task       = s1_req_q.task_id;
  assign chal_res.picked_period     = s1_req_q.period_id;
  assign chal_res.picked_precedence = s1_req_q.precedence_id;

  assign found_n = take || have_best_q;
  assign sel_res = take ? chal_res : best_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_req_q  <= efpjs_pkg::req_t'(s_axis_tdata[$bits(efpjs_pkg::req_t)-1:0]);
      s1_kind_q <= efpjs_pkg::kind_e'(s_axis_tuser);
      s1_last_q <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < int'(NUM_PROCESSORS); p++) begin
        proc_times_q[p] <= '0;
      end
    end else if (commit && (s1_kind_q == efpjs_pkg::KIND_LOAD)) begin
      for (int p = 0; p < int'(NUM_PROCESSORS); p++) begin
        if (int'(s1_req_q.processor_id) == p) begin
          proc_times_q[p] <= s1_req_q.timestamp;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_best_q <= 1'b0;
      seen_q      <= '0;
      best_proc_q <= '0;
    end else if (commit && (s1_kind_q == efpjs_pkg::KIND_JOB)) begin
      if (s1_last_q) begin
        have_best_q <= 1'b0;
        seen_q      <= '0;
      end else begin
        have_best_q <= found_n;
        seen_q      <= seen_q + INDEX_W'(1);
      end
      if (take) begin
        best_proc_q <= s1_req_q.processor_id;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit && (s1_kind_q == efpjs_pkg::KIND_JOB) && take) begin
      best_key_q <= chal_key;
      best_res_q <= chal_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (commit && emit_req) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit && emit_req) begin
      m_found_q <= found_n;
      m_data_q  <= found_n ? sel_res : '0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_found_q;
  assign m_axis_tdata  = m_data_q;

  `EFPJS_ASSERT_NEXT(a_pick_cleared, commit && emit_req, !have_best_q && (seen_q == '0), "pick not cleared after result")
  `EFPJS_ASSERT_IMPL(a_empty_result_zero, m_valid_q && !m_found_q, m_data_q == '0, "empty result carries data")
  `EFPJS_ASSERT_IMPL(a_stall_only_on_held_result, s1_valid_q && !s_axis_tready, m_valid_q && !m_axis_tready && emit_req, "input stalled without a held result")
  `EFPJS_ASSERT_IMPL(a_result_from_close, $rose(m_valid_q), $past(commit && emit_req), "result without a closing request")

endmodule

`default_nettype wire

// ===== tb/edf_fixed_priority_job_select_test.sv =====
`timescale 1ns / 100ps

module edf_fixed_priority_job_select_test;
  import efpjs_pkg::*;

  localparam int unsigned NUM_PROCS      = 8;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned RANDOM_ITEMS   = 1200;
  localparam int unsigned CLEAN_ITEMS    = 230;

  typedef struct packed {
    logic    found;
    result_t res;
  } pick_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  // Selection state mirrored from the accepted requests.
  logic [TIME_W-1:0]  proc_time [NUM_PROCS];
  bit                 have_best;
  logic [INDEX_W-1:0] best_index;
  req_t               best_job;
  logic [INDEX_W-1:0] list_pos;

  pick_t expected_picks [$];
  int    error_count;
  int    sent_count;
  int    idle_cycles;
  bit    tx_idle_en;
  bit    rx_idle_en;
  bit    hold_rx = 1'b0;
  int    rx_gap;

  edf_fixed_priority_job_select #(
    .NUM_PROCESSORS(NUM_PROCS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic void clear_selection();
    have_best  = 1'b0;
    best_index = '0;
    best_job   = '0;
    list_pos   = '0;
  endfunction

  // Same processor: lower priority number, then earlier deadline, then lower task id.
  function automatic bit outranks_best(req_t r);
    logic signed [DL_W-1:0] dl_new;
    logic signed [DL_W-1:0] dl_old;
    dl_new = r.deadline;
    dl_old = best_job.deadline;
    if (r.priority_req != best_job.priority_req) return r.priority_req < best_job.priority_req;
    if (dl_new != dl_old) return dl_new < dl_old;
    return r.task_id < best_job.task_id;
  endfunction

  function automatic void track_selection(kind_e kind, req_t r, bit last);
    logic [INDEX_W-1:0] pos;
    logic [TIME_W-1:0]  mine;
    logic [TIME_W-1:0]  theirs;
    bit                 take;
    pick_t              pick;
    take = 1'b0;
    if (kind == KIND_LOAD) begin
      if (r.processor_id < NUM_PROCS) proc_time[r.processor_id] = r.timestamp;
      return;
    end
    pos = list_pos;
    list_pos = list_pos + 1'b1;
    if (r.processor_id < NUM_PROCS && r.release_time <= proc_time[r.processor_id]) begin
      mine   = proc_time[r.processor_id];
      theirs = (best_job.processor_id < NUM_PROCS) ? proc_time[best_job.processor_id] : '0;
      if (!have_best) take = 1'b1;
      else if (mine < theirs) take = 1'b1;
      else if (r.processor_id == best_job.processor_id && outranks_best(r)) take = 1'b1;
    end
    if (take) begin
      have_best  = 1'b1;
      best_index = pos;
      best_job   = r;
    end
    if (!last) return;
    pick = '0;
    if (have_best) begin
      pick.found                 = 1'b1;
      pick.res.picked_index      = best_index;
      pick.res.picked_task       = best_job.task_id;
      pick.res.picked_period     = best_job.period_id;
      pick.res.picked_precedence = best_job.precedence_id;
    end
    expected_picks = {expected_picks, pick};
    clear_selection();
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Result checker
  always @(posedge clk_i) begin
    pick_t   want;
    result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata);
      if (expected_picks.size() == 0) begin
        report_mismatch("unexpected result", {31'b0, m_axis_tuser}, 32'h0);
      end else begin
        want = expected_picks.pop_front();
        check_field("found", {31'b0, m_axis_tuser}, {31'b0, want.found});
        check_field("picked_index", {24'b0, got.picked_index}, {24'b0, want.res.picked_index});
        check_field("picked_task", {24'b0, got.picked_task}, {24'b0, want.res.picked_task});
        check_field("picked_period", {16'b0, got.picked_period},
                    {16'b0, want.res.picked_period});
        check_field("picked_precedence", {24'b0, got.picked_precedence},
                    {24'b0, want.res.picked_precedence});
      end
    end
  end

  // Receiver: random stall bursts, or a long hold-off while hold_rx is set
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_gap <= 0;
    end else if (hold_rx) begin
      m_axis_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
      rx_gap <= $urandom_range(0, 13);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Valid stays high between back-to-back requests; it only drops for a gap.
  task automatic send_request(kind_e kind, req_t r, bit last);
    int gap;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'(r);
    s_axis_tuser  <= kind;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    track_selection(kind, r, last);
    sent_count++;
  endtask

  task automatic send_load(logic [PROC_W-1:0] proc, logic [TIME_W-1:0] stamp, bit last);
    req_t r;
    r = req_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    r.processor_id = proc;
    r.timestamp    = stamp;
    send_request(KIND_LOAD, r, last);
  endtask

  task automatic send_job(logic [PROC_W-1:0] proc, logic [TIME_W-1:0] rel,
                          logic [PRIO_W-1:0] prio, logic [DL_W-1:0] dl,
                          logic [TASK_W-1:0] tid, logic [PERIOD_W-1:0] period,
                          logic [PREC_W-1:0] prec, bit last);
    req_t r;
    r.timestamp     = TIME_W'($urandom);
    r.processor_id  = proc;
    r.release_time  = rel;
    r.priority_req  = prio;
    r.deadline      = dl;
    r.task_id       = tid;
    r.period_id     = period;
    r.precedence_id = prec;
    send_request(KIND_JOB, r, last);
  endtask

  // Wait for all outstanding picks, then for the pipeline to go quiet.
  task automatic settle();
    int waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (expected_picks.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_picks.size() != 0) begin
      report_mismatch("results never delivered", expected_picks.size(), 0);
      expected_picks.delete();
    end
    repeat (8) @(posedge clk_i);
  endtask

  // Candidate with fields biased toward ties and toward its processor's time.
  task automatic send_random_job(bit last);
    logic [PROC_W-1:0] proc;
    logic [31:0]       t;
    logic [31:0]       rel;
    int unsigned       off;
    proc = $urandom_range(0, NUM_PROCS - 1);
    t    = {1'b0, proc_time[proc]};
    off  = $urandom_range(0, 40);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: rel = (t >= off) ? t - off : 32'h0;
      6:                rel = t;
      7, 8:             rel = (t + off + 1 > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : t + off + 1;
      default:          rel = {1'b0, 31'($urandom)};
    endcase
    send_job(proc, rel[TIME_W-1:0],
             $urandom_range(0, 1) ? PRIO_W'($urandom_range(0, 3)) : PRIO_W'($urandom),
             $urandom_range(0, 1) ? DL_W'($urandom_range(0, 6) - 3) : DL_W'($urandom),
             $urandom_range(0, 1) ? TASK_W'($urandom_range(0, 3)) : TASK_W'($urandom),
             PERIOD_W'($urandom), PREC_W'($urandom), last);
  endtask

  task automatic send_random_load(bit last);
    logic [PROC_W-1:0] proc;
    logic [TIME_W-1:0] stamp;
    proc = $urandom_range(0, NUM_PROCS - 1);
    case ($urandom_range(0, 7))
      0:       stamp = TIME_W'($urandom);
      1:       stamp = '1;
      2:       stamp = '0;
      default: stamp = proc_time[proc] + TIME_W'($urandom_range(0, 30)) - TIME_W'(10);
    endcase
    send_load(proc, stamp, last);
  endtask

  task automatic send_random_list(int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_random_load($urandom_range(0, 1));
      send_random_job(i == len - 1);
    end
  endtask

  task automatic test_directed();
    // nothing eligible, then release equal to the processor time
    send_job(3'd0, 31'd1, 16'd5, 32'd0, 8'd1, 16'd1, 8'd1, 1'b1);
    send_job(3'd0, 31'd0, 16'd5, 32'd0, 8'd1, 16'd2, 8'd3, 1'b1);
    send_load(3'd0, 31'd100, 1'b0);
    send_load(3'd1, 31'd50, 1'b0);
    send_load(3'd7, 31'h7FFF_FFFF, 1'b1);  // last flag on a load is ignored
    // earlier processor time wins; priority, deadline and task tie-breaks on proc 1
    send_job(3'd0, 31'd100, 16'd0, 32'd0, 8'd0, 16'd10, 8'd0, 1'b0);
    send_job(3'd1, 31'd50, 16'hFFFF, 32'h7FFF_FFFF, 8'd20, 16'd11, 8'd1, 1'b0);
    send_job(3'd0, 31'd0, 16'd0, 32'h8000_0000, 8'd0, 16'd12, 8'd2, 1'b0);
    send_job(3'd1, 31'd51, 16'd0, 32'd0, 8'd0, 16'd13, 8'd3, 1'b0);
    send_job(3'd1, 31'd0, 16'hFFFF, -32'sd5, 8'd10, 16'd14, 8'd4, 1'b0);
    send_job(3'd1, 31'd0, 16'hFFFF, -32'sd5, 8'd3, 16'd15, 8'd5, 1'b0);
    send_job(3'd1, 31'd0, 16'hFFFF, -32'sd5, 8'd3, 16'd16, 8'd6, 1'b0);
    send_job(3'd1, 31'd0, 16'hFFFF, 32'h8000_0000, 8'hFF, 16'hFFFF, 8'hFF, 1'b1);
    // time loads in mid-list, including the processor of the current pick
    send_job(3'd0, 31'd0, 16'd1, 32'd0, 8'd1, 16'd20, 8'd0, 1'b0);
    send_job(3'd7, 31'h7FFF_FFFF, 16'd0, 32'd0, 8'd0, 16'd21, 8'd1, 1'b0);
    send_load(3'd0, 31'h7FFF_FFFF, 1'b0);
    send_job(3'd1, 31'd0, 16'd9, 32'd0, 8'd9, 16'd22, 8'd2, 1'b0);
    send_load(3'd1, 31'd0, 1'b1);
    send_job(3'd1, 31'd1, 16'd0, 32'd0, 8'd0, 16'd23, 8'd3, 1'b0);
    send_job(3'd0, 31'd0, 16'd0, 32'd0, 8'd0, 16'd24, 8'd4, 1'b1);
    settle();
  endtask

  // One list longer than the index width; positions wrap.
  task automatic test_long_list();
    send_load(3'd2, 31'd1000, 1'b0);
    for (int i = 0; i < 300; i++) begin
      if (i == 270) send_job(3'd2, 31'd1000, 16'd0, 32'd0, 8'd7, 16'd270, 8'd14, 1'b0);
      else send_job(3'd2, 31'($urandom_range(900, 1100)), 16'($urandom_range(1, 9)),
                    DL_W'($urandom), TASK_W'($urandom), PERIOD_W'($urandom),
                    PREC_W'($urandom), i == 299);
    end
    settle();
  endtask

  task automatic test_random_lists();
    int stop_at;
    stop_at = sent_count + RANDOM_ITEMS;
    while (sent_count < stop_at) begin
      if ($urandom_range(0, 15) == 0) begin
        tx_idle_en = $urandom_range(0, 2) != 0;
        rx_idle_en = $urandom_range(0, 2) != 0;
      end
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 3)) send_random_load($urandom_range(0, 1));
      end
      send_random_list($urandom_range(0, 7) == 0 ? $urandom_range(9, 20)
                                                 : $urandom_range(1, 6));
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    settle();
  endtask

  // Receiver holds off while short lists keep arriving, so the input side stalls.
  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    fork
      begin
        hold_rx <= 1'b1;
        repeat (400) @(posedge clk_i);
        hold_rx <= 1'b0;
      end
      begin
        repeat (25) send_random_list($urandom_range(1, 3));
      end
    join
    tx_idle_en = 1'b1;
    settle();
  endtask

  task automatic test_full_rate();
    int stop_at;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    stop_at = sent_count + CLEAN_ITEMS;
    while (sent_count < stop_at) begin
      if ($urandom_range(0, 3) == 0) send_random_load(1'b0);
      send_random_list($urandom_range(1, 5));
    end
    settle();
  endtask

  initial begin
    for (int p = 0; p < NUM_PROCS; p++) proc_time[p] = '0;
    clear_selection();
    error_count = 0;
    sent_count  = 0;
    idle_cycles = 0;
    tx_idle_en  = 1'b1;
    rx_idle_en  = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_long_list();
    test_random_lists();
    test_backpressure();
    test_full_rate();

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/efpjs_pkg.sv
sv/efpjs_rank.sv
sv/edf_fixed_priority_job_select.sv
tb/edf_fixed_priority_job_select_test.sv
